>>> rtl/core/ndrle_pkg.sv
// Shared types, codes and constants of the nibble-delta run-length decoder.
package ndrle_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned RUN_W      = 17;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned DELTA_W    = 112;

  // remainder unit: one quotient bit per step over a 9-bit dividend
  localparam int unsigned MOD_STEPS  = 9;
  localparam int unsigned MOD_CNT_W  = 4;
  localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IDX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

  // nibble control codes
  localparam logic [3:0] NIB_LAST_DELTA = 4'hD;
  localparam logic [3:0] NIB_LITERAL    = 4'hF;
  localparam logic [7:0] COUNT_ESCAPE   = 8'hFF;
  localparam logic [RUN_W-1:0] RUN_BIAS = 17'd2;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_CTRL  = 3'd1,
    PH_LIT   = 3'd2,
    PH_CNT8  = 3'd3,
    PH_CNT16 = 3'd4,
    PH_DONE  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_INIT    = 3'd1,
    ERR_LIT     = 3'd2,
    ERR_OVERRUN = 3'd3,
    ERR_TRUNC   = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FIRST,
    OP_NIB,
    OP_MOD_STEP,
    OP_ADD_MOD,
    OP_FINAL
  } dp_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_NIB,
    S_MOD,
    S_ADDM,
    S_FIN,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [PIX_W-1:0]   max_idx;
    logic [DELTA_W-1:0] deltas;
    logic [CNT_W-1:0]   total;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [RUN_W-1:0] run;
    logic             last;
    logic             done;
    err_e             err;
  } res_t;

  typedef struct packed {
    logic   load;
    dp_op_e op;
    logic   sel;
    logic   emit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic       phase_first;
    logic       needs_mod;
    logic [1:0] res_cnt;
  } dp_stat_t;

endpackage

>>> rtl/core/ndrle_cfg.sv
// Configuration registers and the registered total pixel count.
module ndrle_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [ndrle_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ndrle_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output ndrle_pkg::cfg_t                     cfg_o
);
  import ndrle_pkg::*;

  logic [7:0]  max_idx_q;
  logic [63:0] delta_lo_q;
  logic [47:0] delta_hi_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [31:0] total_q;
  logic [15:0] width_eff;
  logic [15:0] height_eff;

  // a zero dimension counts as one
  assign width_eff  = (width_q  == 16'd0) ? 16'd1 : width_q;
  assign height_eff = (height_q == 16'd0) ? 16'd1 : height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_idx_q  <= 8'hFF;
      delta_lo_q <= '0;
      delta_hi_q <= '0;
      width_q    <= 16'd1;
      height_q   <= 16'd1;
      total_q    <= 32'd1;
    end else begin
      total_q <= {16'd0, width_eff} * {16'd0, height_eff};
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_MAX_IDX:  max_idx_q  <= cfg_data_i[7:0];
          REG_DELTA_LO: delta_lo_q <= cfg_data_i;
          REG_DELTA_HI: delta_hi_q <= cfg_data_i[47:0];
          REG_WIDTH:    width_q    <= cfg_data_i[15:0];
          REG_HEIGHT:   height_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o.max_idx = max_idx_q;
  assign cfg_o.deltas  = {delta_hi_q, delta_lo_q};
  assign cfg_o.total   = total_q;

endmodule

>>> rtl/core/ndrle_dp.sv
// Datapath: parse state, remainder unit, pixel accounting and result buffer.
module ndrle_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ndrle_pkg::cfg_t   cfg_i,
  input  ndrle_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]        stream_byte_i,
  input  logic              stream_last_i,
  output ndrle_pkg::dp_stat_t stat_o,
  output ndrle_pkg::res_t   res_o
);
  import ndrle_pkg::*;

  phase_e      phase_q, phase_d;
  err_e        err_q, err_d;
  logic [7:0]  last_pix_q, last_pix_d;
  logic [31:0] emitted_q, emitted_d;
  logic [3:0]  pend_q, pend_d;
  logic [15:0] cpart_q, cpart_d;
  logic [1:0]  slot_q, slot_d;
  logic [1:0]  res_cnt_q, res_cnt_d;
  logic [8:0]  rem_q, rem_d;
  logic [8:0]  num_q, num_d;
  logic [7:0]  byte_q;
  logic        blast_q;
  res_t        res_q [2];
  res_t        res_d [2];

  logic [3:0]  nib;
  logic [7:0]  delta;
  logic [7:0]  lit_v;
  logic [8:0]  size9;
  logic [8:0]  trial;
  logic        ev_add;
  logic        ev_fail;
  err_e        ev_code;
  logic [7:0]  ev_pix;
  logic [16:0] ev_run;
  logic [32:0] sum33;
  logic        pix_done;
  logic        last_slot;

  assign nib       = cmd_i.sel ? byte_q[7:4] : byte_q[3:0];
  assign delta     = cfg_i.deltas[{nib, 3'b000} +: 8];
  assign lit_v     = {nib, pend_q};
  assign size9     = {1'b0, cfg_i.max_idx} + 9'd1;
  assign trial     = {rem_q[7:0], num_q[8]};
  assign last_slot = res_cnt_q[1];

  always_comb begin
    phase_d   = phase_q;
    err_d     = err_q;
    last_pix_d = last_pix_q;
    emitted_d = emitted_q;
    pend_d    = pend_q;
    cpart_d   = cpart_q;
    slot_d    = slot_q;
    res_cnt_d = cmd_i.load ? 2'd0 : res_cnt_q;
    rem_d     = rem_q;
    num_d     = num_q;
    res_d     = res_q;
    ev_add    = 1'b0;
    ev_fail   = 1'b0;
    ev_code   = ERR_NONE;
    ev_pix    = last_pix_q;
    ev_run    = '0;
    pix_done  = 1'b0;

    unique case (cmd_i.op)
      OP_FIRST: begin
        if (err_q == ERR_NONE && phase_q == PH_FIRST) begin
          if (byte_q > cfg_i.max_idx) begin
            ev_fail = 1'b1;
            ev_code = ERR_INIT;
          end else begin
            phase_d = PH_CTRL;
            ev_add  = 1'b1;
            ev_pix  = byte_q;
            ev_run  = 17'd1;
          end
        end
      end
      OP_NIB: begin
        if (err_q == ERR_NONE) begin
          case (phase_q)
            PH_CTRL: begin
              if (nib <= NIB_LAST_DELTA) begin
                num_d = {1'b0, last_pix_q} + {1'b0, delta};
                rem_d = '0;
              end else if (nib == NIB_LITERAL) begin
                phase_d = PH_LIT;
                slot_d  = 2'd0;
              end else begin
                phase_d = PH_CNT8;
                slot_d  = 2'd0;
              end
            end
            PH_LIT: begin
              if (slot_q == 2'd0) begin
                pend_d = nib;
                slot_d = 2'd1;
              end else begin
                phase_d = PH_CTRL;
                slot_d  = 2'd0;
                if (lit_v > cfg_i.max_idx) begin
                  ev_fail = 1'b1;
                  ev_code = ERR_LIT;
                end else begin
                  ev_add = 1'b1;
                  ev_pix = lit_v;
                  ev_run = 17'd1;
                end
              end
            end
            PH_CNT8: begin
              if (slot_q == 2'd0) begin
                pend_d = nib;
                slot_d = 2'd1;
              end else begin
                slot_d = 2'd0;
                if (lit_v == COUNT_ESCAPE) begin
                  phase_d = PH_CNT16;
                  cpart_d = '0;
                end else begin
                  phase_d = PH_CTRL;
                  ev_add  = 1'b1;
                  ev_run  = {9'd0, lit_v} + RUN_BIAS;
                end
              end
            end
            PH_CNT16: begin
              if (slot_q == 2'd0 || slot_q == 2'd2) begin
                pend_d = nib;
                slot_d = slot_q + 2'd1;
              end else if (slot_q == 2'd1) begin
                cpart_d = {lit_v, 8'h00};
                slot_d  = 2'd2;
              end else begin
                slot_d  = 2'd0;
                phase_d = PH_CTRL;
                ev_add  = 1'b1;
                ev_run  = {1'b0, cpart_q[15:8], lit_v} + RUN_BIAS;
              end
            end
            default: ;
          endcase
        end
      end
      OP_MOD_STEP: begin
        rem_d = (trial >= size9) ? (trial - size9) : trial;
        num_d = {num_q[7:0], 1'b0};
      end
      OP_ADD_MOD: begin
        ev_add = 1'b1;
        ev_pix = rem_q[7:0];
        ev_run = 17'd1;
      end
      OP_FINAL: begin
        if (blast_q && err_q == ERR_NONE && phase_q != PH_DONE) begin
          if (res_cnt_q != 2'd0) begin
            res_d[last_slot].err = ERR_TRUNC;
          end else begin
            res_d[0]  = '{pix: last_pix_q, run: '0, last: 1'b1, done: 1'b0,
                          err: ERR_TRUNC};
            res_cnt_d = 2'd1;
          end
        end
        if (res_cnt_q != 2'd0) begin
          res_d[last_slot].last = 1'b1;
        end
        if (blast_q) begin
          phase_d    = PH_FIRST;
          err_d      = ERR_NONE;
          last_pix_d = '0;
          emitted_d  = '0;
          pend_d     = '0;
          cpart_d    = '0;
          slot_d     = '0;
        end
      end
      default: ;
    endcase

    // pixel accounting; an overrun turns into a sticky error
    sum33 = {1'b0, emitted_q} + {16'd0, ev_run};
    if (ev_add) begin
      if (sum33 > {1'b0, cfg_i.total}) begin
        ev_fail = 1'b1;
        ev_code = ERR_OVERRUN;
      end else begin
        emitted_d  = sum33[31:0];
        last_pix_d = ev_pix;
        pix_done   = (sum33[31:0] >= cfg_i.total);
        if (pix_done) begin
          phase_d = PH_DONE;
        end
        res_d[res_cnt_q[0]] = '{pix: ev_pix, run: ev_run, last: 1'b0, done: pix_done,
                                err: ERR_NONE};
        res_cnt_d = res_cnt_q + 2'd1;
      end
    end
    if (ev_fail) begin
      err_d = ev_code;
      res_d[res_cnt_q[0]] = '{pix: last_pix_q, run: '0, last: 1'b0, done: 1'b0,
                              err: ev_code};
      res_cnt_d = res_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FIRST;
      err_q      <= ERR_NONE;
      last_pix_q <= '0;
      emitted_q  <= '0;
      pend_q     <= '0;
      cpart_q    <= '0;
      slot_q     <= '0;
      res_cnt_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      err_q      <= err_d;
      last_pix_q <= last_pix_d;
      emitted_q  <= emitted_d;
      pend_q     <= pend_d;
      cpart_q    <= cpart_d;
      slot_q     <= slot_d;
      res_cnt_q  <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q  <= stream_byte_i;
      blast_q <= stream_last_i;
    end
    rem_q <= rem_d;
    num_q <= num_d;
    res_q <= res_d;
  end

  assign stat_o.phase_first = (phase_q == PH_FIRST);
  assign stat_o.needs_mod   = (err_q == ERR_NONE) && (phase_q == PH_CTRL) &&
                              (nib <= NIB_LAST_DELTA);
  assign stat_o.res_cnt     = res_cnt_q;
  assign res_o              = res_q[cmd_i.emit_idx];

endmodule

>>> rtl/core/ndrle_ctrl.sv
// Controller: sequences byte decode, the two nibbles, the remainder steps and result output.
module ndrle_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  ndrle_pkg::dp_stat_t  stat_i,
  output ndrle_pkg::dp_cmd_t   cmd_o
);
  import ndrle_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic                 sel_q, sel_d;
  logic                 emit_q, emit_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    emit_d  = emit_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_BYTE;
        end
      end
      S_BYTE: begin
        sel_d   = 1'b0;
        state_d = stat_i.phase_first ? S_FIN : S_NIB;
      end
      S_NIB: begin
        if (stat_i.needs_mod) begin
          cnt_d   = '0;
          state_d = S_MOD;
        end else if (!sel_q) begin
          sel_d = 1'b1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MOD: begin
        cnt_d = cnt_q + MOD_CNT_W'(1);
        if (cnt_q == MOD_LAST) begin
          state_d = S_ADDM;
        end
      end
      S_ADDM: begin
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = S_NIB;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        emit_d  = 1'b0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.res_cnt == 2'd0) begin
          state_d = S_IDLE;
        end else if (!out_stall_i) begin
          if ({1'b0, emit_q} + 2'd1 == stat_i.res_cnt) begin
            state_d = S_IDLE;
          end else begin
            emit_d = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.sel      = sel_q;
    cmd_o.emit_idx = emit_q;
    in_stall_o     = (state_q != S_IDLE);
    out_valid_o    = (state_q == S_EMIT) && (stat_i.res_cnt != 2'd0);
    unique case (state_q)
      S_BYTE:  cmd_o.op = stat_i.phase_first ? OP_FIRST : OP_NONE;
      S_NIB:   cmd_o.op = OP_NIB;
      S_MOD:   cmd_o.op = OP_MOD_STEP;
      S_ADDM:  cmd_o.op = OP_ADD_MOD;
      S_FIN:   cmd_o.op = OP_FINAL;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
      emit_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      emit_q  <= emit_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/core/nibble_delta_rle_pixel_decoder.sv
// Top level of the nibble-delta run-length pixel decoder.
// Takes one stream byte per item and returns up to two (pixel, run) results per byte, the
// last one flagged. A byte passes an accept state, a decode state, a state per nibble (none
// for the first byte of a span), a finish state and an output state that delivers each
// result while out_stall_i is low, entered also when the byte yields no result. Each delta
// control adds the 9-step restoring remainder unit, which reduces the sum modulo the
// palette size, and an add step. The next byte is taken once every result of the current
// one is delivered.
// Configuration writes are always accepted; write only while the block is idle.
module nibble_delta_rle_pixel_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        stream_byte_i,
  input  logic                              stream_last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        pixel_index_o,
  output logic [16:0]                       run_length_o,
  output logic                              last_of_item_o,
  output logic                              image_done_o,
  output logic [2:0]                        error_code_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ndrle_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ndrle_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ndrle_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     res;

  assign cfg_ready_o = 1'b1;

  ndrle_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ndrle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ndrle_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .stream_byte_i (stream_byte_i),
    .stream_last_i (stream_last_i),
    .stat_o        (stat),
    .res_o         (res)
  );

  assign pixel_index_o  = res.pix;
  assign run_length_o   = res.run;
  assign last_of_item_o = res.last;
  assign image_done_o   = res.done;
  assign error_code_o   = res.err;

  // error-only results carry a zero run and a nonzero code
  a_zero_run_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (run_length_o == 17'd0) |-> (error_code_o != ERR_NONE))
    else $error("zero run without error code");

  // the completing result is a clean pixel run
  a_done_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_done_o |-> (error_code_o == ERR_NONE) && (run_length_o != 17'd0))
    else $error("image_done on an error result");

  // a new item is never taken while results are still being delivered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !out_valid_o)
    else $error("item accepted while results pending");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the nibble-delta run-length pixel decoder.
module tb_top;
  import ndrle_pkg::*;

  localparam logic [3:0]           NIB_RUN          = 4'hE;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam int                   SETTLE_CYCLES    = 40;
  localparam int                   RANDOM_ITEMS     = 700;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [RUN_W-1:0] run;
    logic             last;
    logic             done;
    err_e             err;
  } pixel_run_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            stream_byte_i = 8'h00;
  logic                  stream_last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            pixel_index_o;
  logic [16:0]           run_length_o;
  logic                  last_of_item_o;
  logic                  image_done_o;
  logic [2:0]            error_code_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  nibble_delta_rle_pixel_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .stream_byte_i (stream_byte_i),
    .stream_last_i (stream_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_index_o (pixel_index_o),
    .run_length_o  (run_length_o),
    .last_of_item_o(last_of_item_o),
    .image_done_o  (image_done_o),
    .error_code_o  (error_code_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // register shadow
  logic [7:0]  pal_max;
  logic [63:0] delta_lo;
  logic [47:0] delta_hi;
  logic [15:0] img_w;
  logic [15:0] img_h;

  // decoder shadow state
  phase_e      dec_phase;
  logic [7:0]  cur_pix;
  logic [31:0] pix_emitted;
  logic [3:0]  pend_nib;
  logic [15:0] count_hi;
  err_e        err_state;
  logic [1:0]  nib_slot;

  pixel_run_t  byte_runs[$];
  pixel_run_t  expected_runs[$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  runs_checked = 0;
  int  images_done = 0;
  int  err_seen[5];
  bit  calm = 1'b0;
  int  hold_req = 0;
  int  hold_left = 0;

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 20) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic clear_decoder();
    dec_phase   = PH_FIRST;
    cur_pix     = '0;
    pix_emitted = '0;
    pend_nib    = '0;
    count_hi    = '0;
    err_state   = ERR_NONE;
    nib_slot    = '0;
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    case (idx)
      REG_MAX_IDX:  pal_max  = data[7:0];
      REG_DELTA_LO: delta_lo = data;
      REG_DELTA_HI: delta_hi = data[47:0];
      REG_WIDTH:    img_w    = data[15:0];
      REG_HEIGHT:   img_h    = data[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pixel_total();
    logic [31:0] w;
    logic [31:0] h;
    w = (img_w == 16'd0) ? 32'd1 : {16'd0, img_w};
    h = (img_h == 16'd0) ? 32'd1 : {16'd0, img_h};
    return w * h;
  endfunction

  function automatic logic [7:0] delta_of(logic [3:0] c);
    if (c < 4'd8) return delta_lo[8*c +: 8];
    return delta_hi[8*(c-4'd8) +: 8];
  endfunction

  task automatic push_run(logic [7:0] pix, logic [16:0] run, logic done, err_e err);
    pixel_run_t r;
    r.pix  = pix;
    r.run  = run;
    r.last = 1'b0;
    r.done = done;
    r.err  = err;
    byte_runs.insert(byte_runs.size(), r);
  endtask

  task automatic latch_error(err_e code);
    err_state = code;
    push_run(cur_pix, '0, 1'b0, code);
  endtask

  task automatic emit_pixels(logic [7:0] pix, logic [31:0] run);
    logic [31:0] total;
    logic [31:0] remaining;
    total = pixel_total();
    remaining = (pix_emitted >= total) ? 32'd0 : total - pix_emitted;
    if (run > remaining) begin
      latch_error(ERR_OVERRUN);
      return;
    end
    pix_emitted += run;
    cur_pix = pix;
    if (pix_emitted >= total) dec_phase = PH_DONE;
    push_run(pix, run[16:0], pix_emitted >= total, ERR_NONE);
  endtask

  task automatic decode_nibble(logic [3:0] n);
    logic [7:0]  v;
    logic [8:0]  size;
    logic [8:0]  sum;
    logic [31:0] cnt;
    if (err_state != ERR_NONE) return;
    case (dec_phase)
      PH_CTRL: begin
        if (n <= NIB_LAST_DELTA) begin
          size = {1'b0, pal_max} + 9'd1;
          sum  = {1'b0, cur_pix} + {1'b0, delta_of(n)};
          emit_pixels(8'(sum % size), 32'd1);
        end else if (n == NIB_LITERAL) begin
          dec_phase = PH_LIT;
          nib_slot  = '0;
        end else begin
          dec_phase = PH_CNT8;
          nib_slot  = '0;
        end
      end
      PH_LIT: begin
        if (nib_slot == 2'd0) begin
          pend_nib = n;
          nib_slot = 2'd1;
        end else begin
          v = {n, pend_nib};
          dec_phase = PH_CTRL;
          nib_slot  = '0;
          if (v > pal_max) latch_error(ERR_LIT);
          else emit_pixels(v, 32'd1);
        end
      end
      PH_CNT8: begin
        if (nib_slot == 2'd0) begin
          pend_nib = n;
          nib_slot = 2'd1;
        end else begin
          v = {n, pend_nib};
          nib_slot = '0;
          if (v == COUNT_ESCAPE) begin
            dec_phase = PH_CNT16;
            count_hi  = '0;
          end else begin
            dec_phase = PH_CTRL;
            emit_pixels(cur_pix, 32'(v) + 32'(RUN_BIAS));
          end
        end
      end
      PH_CNT16: begin
        if (nib_slot == 2'd0 || nib_slot == 2'd2) begin
          pend_nib = n;
          nib_slot = nib_slot + 2'd1;
        end else if (nib_slot == 2'd1) begin
          count_hi = {n, pend_nib, 8'h00};
          nib_slot = 2'd2;
        end else begin
          cnt = {16'd0, count_hi} | {24'd0, n, pend_nib};
          nib_slot  = '0;
          dec_phase = PH_CTRL;
          emit_pixels(cur_pix, cnt + 32'(RUN_BIAS));
        end
      end
      default: ;
    endcase
  endtask

  // works out the results of one accepted item and queues them
  task automatic decode_byte(logic [7:0] b, logic last);
    pixel_run_t r;
    byte_runs.delete();
    if (err_state == ERR_NONE) begin
      if (dec_phase == PH_FIRST) begin
        if (b > pal_max) begin
          latch_error(ERR_INIT);
        end else begin
          dec_phase   = PH_CTRL;
          pix_emitted = '0;
          emit_pixels(b, 32'd1);
        end
      end else if (dec_phase != PH_DONE) begin
        decode_nibble(b[3:0]);
        if (dec_phase != PH_DONE) decode_nibble(b[7:4]);
      end
    end
    if (last) begin
      if (err_state == ERR_NONE && dec_phase != PH_DONE) begin
        if (byte_runs.size() > 0) begin
          r = byte_runs[byte_runs.size()-1];
          r.err = ERR_TRUNC;
          byte_runs[byte_runs.size()-1] = r;
        end else begin
          push_run(cur_pix, '0, 1'b0, ERR_TRUNC);
        end
      end
      clear_decoder();
    end
    if (byte_runs.size() > 0) begin
      r = byte_runs[byte_runs.size()-1];
      r.last = 1'b1;
      byte_runs[byte_runs.size()-1] = r;
    end
    foreach (byte_runs[i]) begin
      expected_runs.insert(expected_runs.size(), byte_runs[i]);
      err_seen[byte_runs[i].err]++;
      if (byte_runs[i].done) images_done++;
    end
    bytes_sent++;
  endtask

  task automatic check_result();
    pixel_run_t want;
    runs_checked++;
    if (expected_runs.size() == 0) begin
      flag_mismatch($sformatf("unexpected result pix=%0d run=%0d err=%0d",
                              pixel_index_o, run_length_o, error_code_o));
      return;
    end
    want = expected_runs.pop_front();
    if (pixel_index_o !== want.pix)
      flag_mismatch($sformatf("pixel_index %0d, want %0d", pixel_index_o, want.pix));
    if (run_length_o !== want.run)
      flag_mismatch($sformatf("run_length %0d, want %0d", run_length_o, want.run));
    if (last_of_item_o !== want.last)
      flag_mismatch($sformatf("last_of_item %0b, want %0b", last_of_item_o, want.last));
    if (image_done_o !== want.done)
      flag_mismatch($sformatf("image_done %0b, want %0b", image_done_o, want.done));
    if (error_code_o !== want.err)
      flag_mismatch($sformatf("error_code %0d, want %0d", error_code_o, want.err));
  endtask

  // result side: check, then decide the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 13);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    if (!calm && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    stream_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_byte(b, last);
  endtask

  task automatic send_span(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // lets the block settle; items that cause nothing may still be in flight
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] mx, logic [63:0] lo, logic [47:0] hi,
                            logic [15:0] w, logic [15:0] h);
    write_reg(REG_MAX_IDX, {56'd0, mx});
    write_reg(REG_DELTA_LO, lo);
    write_reg(REG_DELTA_HI, {16'd0, hi});
    write_reg(REG_WIDTH, {48'd0, w});
    write_reg(REG_HEIGHT, {48'd0, h});
  endtask

  // every control kind in one span, with wrap of the palette and ignored tail
  task automatic test_full_span();
    set_config(8'd9, 64'h0807060504030201, 48'h0E0D0C0B0A09, 16'd4, 16'd2);
    send_span('{8'h03, 8'h21, 8'h5F, 8'hE0, 8'h01, 8'hFD});
    wait_idle();
  endtask

  task automatic test_literal_error();
    send_span('{8'h00, 8'hFF, 8'h0F});
    wait_idle();
  endtask

  task automatic test_overrun();
    send_span('{8'h00, 8'h0E, 8'h01});
    wait_idle();
  endtask

  task automatic test_truncation();
    send_span('{8'h01, 8'h10});
    send_span('{8'h02, 8'h0F});
    wait_idle();
  endtask

  // 16-bit escape count of 0xFFFF on the largest image
  task automatic test_long_run();
    set_config(8'd255, {$urandom, $urandom}, 48'({$urandom, $urandom}), 16'hFFFF, 16'hFFFF);
    send_span('{8'h07, 8'hFE, 8'hFF, 8'hFF, 8'h0F});
    wait_idle();
  endtask

  // zero sizes read as one; single-entry palette; spare register indexes
  task automatic test_zero_dims();
    set_config(8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd0, 16'd0);
    write_reg(REG_FIRST_UNUSED + 3'($urandom_range(2)), {$urandom, $urandom});
    send_span('{8'h00});
    send_span('{8'h01});
    wait_idle();
  endtask

  // pixel count lowered between items of one span
  task automatic test_midspan_resize();
    set_config(8'd255, 64'h0101010101010101, 48'h010101010101, 16'd4, 16'd4);
    send_byte(8'h01, 1'b0);
    wait_idle();
    write_reg(REG_HEIGHT, 64'd0);
    send_byte(8'h3E, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  // result side holds off while items keep coming
  task automatic test_backpressure();
    set_config(8'd200, {$urandom, $urandom}, 48'({$urandom, $urandom}), 16'd100, 16'd100);
    hold_req = 300;
    send_byte(8'h05, 1'b0);
    repeat (30) send_byte(8'($urandom_range(255) & 8'hDD), 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic random_config();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(4))
      0: d[7:0] = 8'd255;
      1: d[7:0] = 8'd0;
      2: d[7:0] = 8'($urandom_range(15));
      default: d[7:0] = 8'($urandom_range(255));
    endcase
    write_reg(REG_MAX_IDX, d);
    write_reg(REG_DELTA_LO, {$urandom, $urandom});
    write_reg(REG_DELTA_HI, {$urandom, $urandom});
    d = {$urandom, $urandom};
    d[15:0] = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
    write_reg(REG_WIDTH, d);
    d = {$urandom, $urandom};
    d[15:0] = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(6));
    write_reg(REG_HEIGHT, d);
    if ($urandom_range(3) == 0)
      write_reg(REG_FIRST_UNUSED + 3'($urandom_range(2)), {$urandom, $urandom});
  endtask

  function automatic logic [7:0] pick_pixel();
    if ($urandom_range(9) != 0) return 8'($urandom_range(pal_max));
    return 8'($urandom);
  endfunction

  // mostly well-formed spans with random content, some noise
  task automatic build_span(output logic [7:0] bytes[$]);
    logic [3:0]  nibs[$];
    logic [7:0]  v;
    logic [15:0] c16;
    bytes.delete();
    bytes.insert(bytes.size(), pick_pixel());
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 8)) bytes.insert(bytes.size(), 8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: nibs.insert(nibs.size(), 4'($urandom_range(13)));
        11, 12, 13: begin
          v = pick_pixel();
          nibs.insert(nibs.size(), NIB_LITERAL);
          nibs.insert(nibs.size(), v[3:0]);
          nibs.insert(nibs.size(), v[7:4]);
        end
        14, 15, 16: begin
          v = ($urandom_range(4) == 0) ? 8'($urandom_range(254)) : 8'($urandom_range(12));
          nibs.insert(nibs.size(), NIB_RUN);
          nibs.insert(nibs.size(), v[3:0]);
          nibs.insert(nibs.size(), v[7:4]);
        end
        17, 18: begin
          c16 = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(20));
          nibs.insert(nibs.size(), NIB_RUN);
          nibs.insert(nibs.size(), COUNT_ESCAPE[3:0]);
          nibs.insert(nibs.size(), COUNT_ESCAPE[7:4]);
          nibs.insert(nibs.size(), c16[11:8]);
          nibs.insert(nibs.size(), c16[15:12]);
          nibs.insert(nibs.size(), c16[3:0]);
          nibs.insert(nibs.size(), c16[7:4]);
        end
        default: nibs.insert(nibs.size(), 4'($urandom));
      endcase
    end
    if (nibs.size() % 2 != 0) nibs.insert(nibs.size(), 4'($urandom));
    for (int i = 0; i < nibs.size(); i += 2) bytes.insert(bytes.size(), {nibs[i+1], nibs[i]});
  endtask

  task automatic test_random_spans();
    logic [7:0] span[$];
    int         n;
    n = 0;
    while (bytes_sent < RANDOM_ITEMS) begin
      calm = (n >= 20 && n < 40);
      if ($urandom_range(3) == 0) begin
        wait_idle();
        random_config();
      end
      build_span(span);
      send_span(span);
      n++;
    end
    calm = 1'b0;
  endtask

  initial begin
    #(8 * 600_000);
    $display("nibble_delta_rle_pixel_decoder test failed");
    $finish;
  end

  initial begin
    int waited;
    foreach (err_seen[i]) err_seen[i] = 0;
    pal_max  = 8'd255;
    delta_lo = '0;
    delta_hi = '0;
    img_w    = 16'd1;
    img_h    = 16'd1;
    clear_decoder();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_span();
    test_literal_error();
    test_overrun();
    test_truncation();
    test_long_run();
    test_zero_dims();
    test_midspan_resize();
    test_backpressure();
    test_random_spans();

    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_runs.size() != 0 && waited < 100_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_runs.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_runs.size()));

    $display("Sent %0d stream bytes, checked %0d results, %0d images completed.",
             bytes_sent, runs_checked, images_done);
    $display("Errors seen: bad index %0d, bad literal %0d, overrun %0d, truncated %0d.",
             err_seen[ERR_INIT], err_seen[ERR_LIT], err_seen[ERR_OVERRUN],
             err_seen[ERR_TRUNC]);
    if (mismatches == 0) begin
      $display("nibble_delta_rle_pixel_decoder test passed");
    end else begin
      $display("nibble_delta_rle_pixel_decoder test failed");
    end
    $finish;
  end

endmodule
